>>> hdl/ppb_pkg.sv
// ppb_pkg: constants, opcode and status codes for the PCM ping-pong buffer.
// No dependencies; used by pcm_ping_pong_buffer_unit.
`default_nettype none

package ppb_pkg;

  localparam int SLOT_SAMPLES     = 2048;
  localparam int BYTES_PER_SAMPLE = 2;

  localparam int DEPTH    = 2 * SLOT_SAMPLES;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int FILL_W   = $clog2(SLOT_SAMPLES + 1);

  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int SAMPLE_W = 16;
  localparam int OFFSET_W = 11;
  localparam int CNT_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PRODUCE = 3'd0,
    OP_RELEASE = 3'd1,
    OP_READ    = 3'd2,
    OP_LATENCY = 3'd3,
    OP_ERROR   = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CAPTURED  = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NONE_FULL = 3'd3,
    ST_NOTED     = 3'd4,
    ST_READ_DONE = 3'd5
  } status_e;

endpackage

`default_nettype wire

>>> hdl/pcm_ping_pong_buffer_unit.sv
// pcm_ping_pong_buffer_unit: two-slot ping-pong sample buffer with event counters.
// Depends on ppb_pkg and ppb_ram.
//
// One request is taken per cycle and gives one result in the next cycle; the
// input is blocked only while a result waits and out_ready_i is low. Slot
// state and counters update at the accepting edge; the sample store is a
// 2*SLOT_SAMPLES-entry RAM whose registered read port supplies read_sample_o
// in the result cycle. Counter and fullness outputs show the state after the
// request. The store needs no clearing after reset.
`default_nettype none

module pcm_ping_pong_buffer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ppb_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [ppb_pkg::SAMPLE_W-1:0]  sample_value_i,
  input  wire logic                          chunk_start_i,
  input  wire logic [ppb_pkg::OFFSET_W-1:0]  read_offset_i,
  input  wire logic [ppb_pkg::CNT_W-1:0]     latency_us_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ppb_pkg::STATUS_W-1:0]       status_o,
  output logic                               has_full_o,
  output logic                               full_slot_o,
  output logic [ppb_pkg::SAMPLE_W-1:0]       read_sample_o,
  output logic [ppb_pkg::CNT_W-1:0]          samples_stored_o,
  output logic [ppb_pkg::CNT_W-1:0]          chunks_released_o,
  output logic [ppb_pkg::CNT_W-1:0]          overflow_events_o,
  output logic [ppb_pkg::CNT_W-1:0]          dropped_samples_o,
  output logic [ppb_pkg::CNT_W-1:0]          dropped_bytes_o,
  output logic [ppb_pkg::CNT_W-1:0]          write_errors_o,
  output logic [ppb_pkg::CNT_W-1:0]          max_latency_o
);

  import ppb_pkg::*;

  logic              accept;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic              rd_ok_q, rd_ok_d;

  logic [FILL_W-1:0] slot_fill_q [2];
  logic [FILL_W-1:0] slot_fill_d [2];
  logic [1:0]        slot_full_q, slot_full_d;
  logic              writer_slot_q, writer_slot_d;
  logic              reader_slot_q, reader_slot_d;
  logic              dropping_q, dropping_d;
  logic [CNT_W-1:0]  captured_q, captured_d;
  logic [CNT_W-1:0]  released_q, released_d;
  logic [CNT_W-1:0]  overflow_q, overflow_d;
  logic [CNT_W-1:0]  drop_smp_q, drop_smp_d;
  logic [CNT_W-1:0]  drop_byt_q, drop_byt_d;
  logic [CNT_W-1:0]  errors_q, errors_d;
  logic [CNT_W-1:0]  peak_q, peak_d;

  logic              cur_has_full;
  logic              cur_full_slot;
  logic              wslot;
  logic              dropping_eff;
  logic [FILL_W-1:0] pos;
  logic [FILL_W-1:0] new_fill;
  logic              offset_ok;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // reader's slot unless only the other one is full
  assign cur_has_full  = |slot_full_q;
  assign cur_full_slot = (slot_full_q[reader_slot_q] || !slot_full_q[~reader_slot_q]) ?
                         reader_slot_q : ~reader_slot_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    rd_ok_d       = rd_ok_q;
    slot_fill_d   = slot_fill_q;
    slot_full_d   = slot_full_q;
    writer_slot_d = writer_slot_q;
    reader_slot_d = reader_slot_q;
    dropping_d    = dropping_q;
    captured_d    = captured_q;
    released_d    = released_q;
    overflow_d    = overflow_q;
    drop_smp_d    = drop_smp_q;
    drop_byt_d    = drop_byt_q;
    errors_d      = errors_q;
    peak_d        = peak_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wslot         = writer_slot_q ^ slot_full_q[writer_slot_q];
    dropping_eff  = dropping_q && !chunk_start_i;
    pos           = slot_fill_q[wslot];
    if (pos >= FILL_W'(SLOT_SAMPLES)) begin
      pos = FILL_W'(SLOT_SAMPLES - 1);
    end
    new_fill  = pos + FILL_W'(1);
    ram_waddr = wslot ? ADDR_W'(SLOT_SAMPLES) + ADDR_W'(pos) : ADDR_W'(pos);
    offset_ok = 32'(read_offset_i) < 32'(SLOT_SAMPLES);
    ram_raddr = cur_full_slot ? ADDR_W'(SLOT_SAMPLES) + ADDR_W'(read_offset_i)
                              : ADDR_W'(read_offset_i);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_NOTED;
      rd_ok_d     = 1'b0;
      unique case (opcode_i)
        OP_PRODUCE: begin
          dropping_d = dropping_eff;
          if (dropping_eff || (&slot_full_q)) begin
            if (!dropping_eff) begin
              overflow_d = overflow_q + CNT_W'(1);
              dropping_d = 1'b1;
            end
            drop_smp_d = drop_smp_q + CNT_W'(1);
            drop_byt_d = drop_byt_q + CNT_W'(BYTES_PER_SAMPLE);
            status_d   = ST_DROPPED;
          end else begin
            ram_we             = 1'b1;
            slot_fill_d[wslot] = new_fill;
            captured_d         = captured_q + CNT_W'(1);
            writer_slot_d      = wslot;
            if (new_fill >= FILL_W'(SLOT_SAMPLES)) begin
              slot_full_d[wslot] = 1'b1;
              writer_slot_d      = !wslot;
            end
            status_d = ST_CAPTURED;
          end
        end
        OP_RELEASE: begin
          if (!cur_has_full) begin
            status_d = ST_NONE_FULL;
          end else begin
            slot_full_d[cur_full_slot] = 1'b0;
            slot_fill_d[cur_full_slot] = '0;
            reader_slot_d              = !cur_full_slot;
            released_d                 = released_q + CNT_W'(1);
            status_d                   = ST_RELEASED;
          end
        end
        OP_READ: begin
          if (!cur_has_full) begin
            status_d = ST_NONE_FULL;
          end else begin
            ram_re   = offset_ok;
            rd_ok_d  = offset_ok;
            status_d = ST_READ_DONE;
          end
        end
        OP_LATENCY: begin
          if (latency_us_i > peak_q) begin
            peak_d = latency_us_i;
          end
        end
        OP_ERROR: begin
          errors_d = errors_q + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      status_q       <= ST_CAPTURED;
      rd_ok_q        <= 1'b0;
      slot_fill_q[0] <= '0;
      slot_fill_q[1] <= '0;
      slot_full_q    <= '0;
      writer_slot_q  <= 1'b0;
      reader_slot_q  <= 1'b0;
      dropping_q     <= 1'b0;
      captured_q     <= '0;
      released_q     <= '0;
      overflow_q     <= '0;
      drop_smp_q     <= '0;
      drop_byt_q     <= '0;
      errors_q       <= '0;
      peak_q         <= '0;
    end else begin
      out_valid_q    <= out_valid_d;
      status_q       <= status_d;
      rd_ok_q        <= rd_ok_d;
      slot_fill_q[0] <= slot_fill_d[0];
      slot_fill_q[1] <= slot_fill_d[1];
      slot_full_q    <= slot_full_d;
      writer_slot_q  <= writer_slot_d;
      reader_slot_q  <= reader_slot_d;
      dropping_q     <= dropping_d;
      captured_q     <= captured_d;
      released_q     <= released_d;
      overflow_q     <= overflow_d;
      drop_smp_q     <= drop_smp_d;
      drop_byt_q     <= drop_byt_d;
      errors_q       <= errors_d;
      peak_q         <= peak_d;
    end
  end

  ppb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign has_full_o         = cur_has_full;
  assign full_slot_o        = cur_full_slot;
  assign read_sample_o      = rd_ok_q ? ram_rdata : '0;
  assign samples_stored_o   = captured_q;
  assign chunks_released_o  = released_q;
  assign overflow_events_o  = overflow_q;
  assign dropped_samples_o  = drop_smp_q;
  assign dropped_bytes_o    = drop_byt_q;
  assign write_errors_o     = errors_q;
  assign max_latency_o      = peak_q;

  // a full slot always holds a whole slot of samples
  a_full_means_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!slot_full_q[0] || slot_fill_q[0] == FILL_W'(SLOT_SAMPLES)) &&
    (!slot_full_q[1] || slot_fill_q[1] == FILL_W'(SLOT_SAMPLES)))
    else $error("full slot with short fill");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_fill_q[0] <= FILL_W'(SLOT_SAMPLES) && slot_fill_q[1] <= FILL_W'(SLOT_SAMPLES))
    else $error("slot fill beyond slot size");

  a_drop_sets_dropping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_d == ST_DROPPED |=> dropping_q)
    else $error("dropped sample without dropping chunk");

  a_rd_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ok_q |-> status_q == ST_READ_DONE)
    else $error("read data flagged for non-read result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input blocked with empty result register");

endmodule

`default_nettype wire

>>> hdl/ppb_ram.sv
// ppb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ppb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
